FILE: design/bgd_pkg.sv
// Shared types and constants for the group decoder.
// Used by every module of the block except bgd_ram; no dependencies.
`timescale 1ns / 1ps

package bgd_pkg;

  // Character and code widths
  localparam int CHAR_W    = 8;
  localparam int CODE_W    = 6;
  localparam int NUM_CHARS = 256;
  localparam int ALPHA_SIZE = 64;
  localparam int CNT_W     = 7;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Kinds of queue entries
  localparam logic [1:0] KIND_CODE      = 2'd0;
  localparam logic [1:0] KIND_BAD_ALPHA = 2'd1;
  localparam logic [1:0] KIND_BAD_CHAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ALPHA = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHAR  = 2'd2;

  // Position of the last character of a group
  localparam logic [1:0] LAST_POS = 2'd3;

  typedef struct packed {
    logic              start_req;
    logic [CHAR_W-1:0] char_code;
  } chr_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
  } res_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        pos;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

FILE: design/binscii_group_decoder.sv
// Group decoder: one character per cycle, back to back, while chr_stall is low.
// A result transaction passes from the edge that accepts the character causing
// it through the code lookup stage, the four-entry queue and the output register.
// Throughput is set by the single-read code RAM: one character a cycle when not stalled.
// Reset clears all control state and the alphabet valid bits at once; no
// clearing pass runs and the block is ready in the cycle after reset.
`timescale 1ns / 1ps

module binscii_group_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          chr_valid,
  output logic          chr_stall,
  input  bgd_pkg::chr_t chr,
  output logic          res_valid,
  input  logic          res_stall,
  output bgd_pkg::res_t res
);

  logic            push_valid;
  bgd_pkg::entry_t push_entry;
  logic            fifo_full;
  logic            fifo_pop;
  logic            fifo_not_empty;
  bgd_pkg::entry_t fifo_head;

  // Front: alphabet load, classification, code lookup
  bgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chr_valid  (chr_valid),
    .chr_stall  (chr_stall),
    .chr        (chr),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_full  (fifo_full)
  );

  // Queue between the two halves
  bgd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (fifo_pop),
    .not_empty  (fifo_not_empty),
    .head       (fifo_head)
  );

  // Back: group assembly and result register
  bgd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (fifo_not_empty),
    .entry       (fifo_head),
    .pop         (fifo_pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

FILE: design/bgd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bgd_front.sv
// Front end: accepts characters, loads the alphabet, classifies characters
// and looks up codes. Depends on bgd_pkg and bgd_ram.
`timescale 1ns / 1ps

module bgd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            chr_valid,
  output logic            chr_stall,
  input  bgd_pkg::chr_t   chr,
  output logic            push_valid,
  output bgd_pkg::entry_t push_entry,
  input  logic            push_full
);

  logic [bgd_pkg::NUM_CHARS-1:0] code_valid;
  logic [bgd_pkg::NUM_CHARS-1:0] code_valid_next;
  logic [bgd_pkg::CNT_W-1:0]     alpha_cnt;
  logic [1:0]                    grp_pos;
  logic                          halted;

  logic                          stg_valid;
  logic [1:0]                    stg_kind;
  logic [1:0]                    stg_pos;
  logic [bgd_pkg::CODE_W-1:0]    ram_rdata;

  logic                          accept;
  logic                          blank;
  logic                          vbit;
  logic [bgd_pkg::CNT_W-1:0]     cnt_eff;
  logic [1:0]                    pos_eff;
  logic                          halted_eff;

  logic [bgd_pkg::CNT_W-1:0]     alpha_cnt_next;
  logic [1:0]                    grp_pos_next;
  logic                          halted_next;
  logic                          load_wr;
  logic                          rd_en;
  logic                          emit;
  logic [1:0]                    emit_kind;

  // Stage drains into the queue unless the queue is full
  assign push_valid = stg_valid;
  assign push_entry = '{kind: stg_kind, pos: stg_pos, code: ram_rdata};
  assign chr_stall  = stg_valid && push_full;
  assign accept     = chr_valid && !chr_stall;

  // Classify the character
  assign blank = (chr.char_code == 8'h20) ||
                 ((chr.char_code >= 8'h09) && (chr.char_code <= 8'h0d));

  // A start clears all state before the character is handled
  assign vbit       = chr.start_req ? 1'b0 : code_valid[chr.char_code];
  assign cnt_eff    = chr.start_req ? '0 : alpha_cnt;
  assign pos_eff    = chr.start_req ? 2'd0 : grp_pos;
  assign halted_eff = chr.start_req ? 1'b0 : halted;

  // Decide what the character does
  always_comb begin
    alpha_cnt_next = cnt_eff;
    grp_pos_next   = pos_eff;
    halted_next    = halted_eff;
    load_wr        = 1'b0;
    rd_en          = 1'b0;
    emit           = 1'b0;
    emit_kind      = bgd_pkg::KIND_CODE;
    if (!halted_eff) begin
      if (cnt_eff < bgd_pkg::CNT_W'(bgd_pkg::ALPHA_SIZE)) begin
        if (blank || vbit) begin
          emit        = 1'b1;
          emit_kind   = bgd_pkg::KIND_BAD_ALPHA;
          halted_next = 1'b1;
        end else begin
          load_wr        = 1'b1;
          alpha_cnt_next = cnt_eff + 1'b1;
        end
      end else if ((pos_eff == 2'd0) && blank) begin
        // skip whitespace between groups
      end else if (!vbit) begin
        emit         = 1'b1;
        emit_kind    = bgd_pkg::KIND_BAD_CHAR;
        halted_next  = 1'b1;
        grp_pos_next = 2'd0;
      end else begin
        emit         = 1'b1;
        rd_en        = 1'b1;
        grp_pos_next = pos_eff + 2'd1;
      end
    end
  end

  // Start clears the alphabet valid bits, a load sets one
  always_comb begin
    code_valid_next = chr.start_req ? '0 : code_valid;
    if (load_wr) begin
      code_valid_next[chr.char_code] = 1'b1;
    end
  end

  // Reverse alphabet: character to code
  bgd_ram #(
    .WIDTH (bgd_pkg::CODE_W),
    .DEPTH (bgd_pkg::NUM_CHARS)
  ) u_code_ram (
    .clk   (clk),
    .we    (accept && load_wr),
    .waddr (chr.char_code),
    .wdata (alpha_cnt[bgd_pkg::CODE_W-1:0] & {bgd_pkg::CODE_W{!chr.start_req}}),
    .re    (accept && rd_en),
    .raddr (chr.char_code),
    .rdata (ram_rdata)
  );

  // Hold decoder state; clear valid bits on start
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= '0;
      alpha_cnt  <= '0;
      grp_pos    <= 2'd0;
      halted     <= 1'b0;
    end else if (accept) begin
      code_valid <= code_valid_next;
      alpha_cnt  <= alpha_cnt_next;
      grp_pos    <= grp_pos_next;
      halted     <= halted_next;
    end
  end

  // Advance the lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept && emit) begin
      stg_valid <= 1'b1;
    end else if (push_valid && !push_full) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      stg_kind <= emit_kind;
      stg_pos  <= pos_eff;
    end
  end

endmodule

FILE: design/bgd_fifo.sv
// Short queue of classified entries between front and back.
// Depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bgd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output bgd_pkg::entry_t head
);

  bgd_pkg::entry_t             slots [bgd_pkg::FIFO_DEPTH];
  logic [bgd_pkg::FIFO_AW-1:0] wr_ptr;
  logic [bgd_pkg::FIFO_AW-1:0] rd_ptr;
  logic [bgd_pkg::FIFO_AW:0]   count;

  assign full      = (count == (bgd_pkg::FIFO_AW+1)'(bgd_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && not_empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && not_empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: design/bgd_back.sv
// Back end: gathers codes into groups and forms result transactions.
// Depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            entry_valid,
  input  bgd_pkg::entry_t entry,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_stall,
  output bgd_pkg::res_t   res
);

  logic [bgd_pkg::CODE_W-1:0] held0;
  logic [bgd_pkg::CODE_W-1:0] held1;
  logic [bgd_pkg::CODE_W-1:0] held2;
  logic                       produces;
  bgd_pkg::res_t              res_next;

  assign pop = entry_valid && (!res_valid || !res_stall);

  // Work out whether the entry gives a result, and its value
  always_comb begin
    produces = 1'b0;
    res_next = '0;
    case (entry.kind)
      bgd_pkg::KIND_CODE: begin
        if (entry.pos == bgd_pkg::LAST_POS) begin
          produces             = 1'b1;
          res_next.status      = bgd_pkg::STATUS_OK;
          res_next.byte_first  = {entry.code, held2[5:4]};
          res_next.byte_second = {held2[3:0], held1[5:2]};
          res_next.byte_third  = {held1[1:0], held0};
        end
      end
      bgd_pkg::KIND_BAD_ALPHA: begin
        produces        = 1'b1;
        res_next.status = bgd_pkg::STATUS_BAD_ALPHA;
      end
      bgd_pkg::KIND_BAD_CHAR: begin
        produces        = 1'b1;
        res_next.status = bgd_pkg::STATUS_BAD_CHAR;
      end
      default: begin
        produces = 1'b0;
      end
    endcase
  end

  // Hold the first three codes of a group
  always_ff @(posedge clk) begin
    if (pop && (entry.kind == bgd_pkg::KIND_CODE)) begin
      case (entry.pos)
        2'd0:    held0 <= entry.code;
        2'd1:    held1 <= entry.code;
        2'd2:    held2 <= entry.code;
        default: held2 <= held2;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && produces) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produces) begin
      res <= res_next;
    end
  end

endmodule
